// ===== rtl/tfuv_pkg.sv =====
// Shared constants for the triangle flattening pipeline.
// No dependencies; the top level and the testbench take names from here by scope.
package tfuv_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int OUT_W = 34;
  localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

endpackage

// ===== rtl/tfuv_mul.sv =====
// Two-stage unsigned multiplier built from half-width partial products.
// Depends on nothing; stages advance on en.
module tfuv_mul #(
  parameter int W = 32
) (
  input  logic           clk,
  input  logic           en,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic [2*W-1:0] p
);

  localparam int H  = (W + 1) / 2;
  localparam int G  = W - H;
  localparam int GG = 2 * G;
  localparam int HH = 2 * H;
  localparam int PW = 2 * W;

  logic [GG-1:0] hh;
  logic [W-1:0]  hl;
  logic [W-1:0]  lh;
  logic [HH-1:0] ll;
  logic [W:0]    mid;

  always_ff @(posedge clk) begin
    if (en) begin
      hh <= GG'(a[W-1:H]) * GG'(b[W-1:H]);
      hl <= W'(a[W-1:H]) * W'(b[H-1:0]);
      lh <= W'(a[H-1:0]) * W'(b[W-1:H]);
      ll <= HH'(a[H-1:0]) * HH'(b[H-1:0]);
    end
  end

  assign mid = {1'b0, hl} + {1'b0, lh};

  always_ff @(posedge clk) begin
    if (en) begin
      p <= PW'({hh, {HH{1'b0}}}) + PW'({mid, {H{1'b0}}}) + PW'(ll);
    end
  end

endmodule

// ===== rtl/tfuv_front.sv =====
// Front of the pipeline: edge vectors, squared edge length, cross product
// squared norm and signed dot product. Uses tfuv_mul.
module tfuv_front #(
  parameter int CW = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [CW-1:0]     p1 [3],
  input  logic [CW-1:0]     p2 [3],
  input  logic [CW-1:0]     p3 [3],
  output logic              out_valid,
  output logic [2*CW+1:0]   l2,
  output logic [4*CW+3:0]   c2,
  output logic [2*CW+1:0]   dot_mag,
  output logic              dot_neg
);

  localparam int PW  = 2 * CW;
  localparam int XW  = 2 * CW + 2;
  localparam int DTW = 2 * CW + 3;
  localparam int L2W = 2 * CW + 2;
  localparam int CXW = 2 * CW + 1;
  localparam int C2W = 4 * CW + 4;

  function automatic logic [DTW-1:0] sgn(input logic [PW-1:0] m, input logic n);
    sgn = n ? (DTW'(0) - DTW'(m)) : DTW'(m);
  endfunction

  // stage 1: edge vectors as sign and magnitude
  logic [CW-1:0] e_mag [3];
  logic [CW-1:0] f_mag [3];
  logic [5:0]    ng1, ng2, ng3;
  logic [CW:0]   de [3];
  logic [CW:0]   df [3];
  logic          v1, v2, v3, v4, v5, v6, v7, v8;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      de[i] = {p2[i][CW-1], p2[i]} - {p1[i][CW-1], p1[i]};
      df[i] = {p3[i][CW-1], p3[i]} - {p1[i][CW-1], p1[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e_mag[i] <= de[i][CW] ? CW'((CW + 1)'(0) - de[i]) : de[i][CW-1:0];
        f_mag[i] <= df[i][CW] ? CW'((CW + 1)'(0) - df[i]) : df[i][CW-1:0];
      end
      ng1 <= {df[2][CW], df[1][CW], df[0][CW], de[2][CW], de[1][CW], de[0][CW]};
      ng2 <= ng1;
      ng3 <= ng2;
    end
  end

  // stages 2-3: products
  logic [PW-1:0] sq [3];
  logic [PW-1:0] dt [3];
  logic [PW-1:0] ca [3];
  logic [PW-1:0] cb [3];

  for (genvar k = 0; k < 3; k++) begin : g_prod
    tfuv_mul #(.W(CW)) u_sq (.clk, .en, .a(e_mag[k]), .b(e_mag[k]), .p(sq[k]));
    tfuv_mul #(.W(CW)) u_dt (.clk, .en, .a(e_mag[k]), .b(f_mag[k]), .p(dt[k]));
    tfuv_mul #(.W(CW)) u_ca (.clk, .en, .a(e_mag[(k + 1) % 3]),
                             .b(f_mag[(k + 2) % 3]), .p(ca[k]));
    tfuv_mul #(.W(CW)) u_cb (.clk, .en, .a(e_mag[(k + 2) % 3]),
                             .b(f_mag[(k + 1) % 3]), .p(cb[k]));
  end

  // stage 4: signed sums
  logic [XW-1:0]  cross4 [3];
  logic [DTW-1:0] dot4;
  logic [L2W-1:0] l2_4;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        cross4[k] <= XW'(sgn(ca[k], ng3[(k + 1) % 3] ^ ng3[3 + (k + 2) % 3])
                       - sgn(cb[k], ng3[(k + 2) % 3] ^ ng3[3 + (k + 1) % 3]));
      end
      dot4 <= sgn(dt[0], ng3[0] ^ ng3[3]) + sgn(dt[1], ng3[1] ^ ng3[4])
            + sgn(dt[2], ng3[2] ^ ng3[5]);
      l2_4 <= L2W'(sq[0]) + L2W'(sq[1]) + L2W'(sq[2]);
    end
  end

  // stage 5: magnitudes
  logic [CXW-1:0] cx5 [3];
  logic [L2W-1:0] l2_5, l2_6, l2_7;
  logic [L2W-1:0] dm5, dm6, dm7;
  logic           dn5, dn6, dn7;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        cx5[k] <= cross4[k][XW-1] ? CXW'(XW'(0) - cross4[k]) : CXW'(cross4[k]);
      end
      dn5  <= dot4[DTW-1];
      dm5  <= dot4[DTW-1] ? L2W'(DTW'(0) - dot4) : L2W'(dot4);
      l2_5 <= l2_4;
      l2_6 <= l2_5;
      l2_7 <= l2_6;
      dm6  <= dm5;
      dm7  <= dm6;
      dn6  <= dn5;
      dn7  <= dn6;
    end
  end

  // stages 6-7: squares of the cross components, stage 8: their sum
  logic [2*CXW-1:0] cs [3];

  for (genvar k = 0; k < 3; k++) begin : g_csq
    tfuv_mul #(.W(CXW)) u_cs (.clk, .en, .a(cx5[k]), .b(cx5[k]), .p(cs[k]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2      <= C2W'(cs[0]) + C2W'(cs[1]) + C2W'(cs[2]);
      l2      <= l2_7;
      dot_mag <= dm7;
      dot_neg <= dn7;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0; v8 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3;
      v5 <= v4; v6 <= v5; v7 <= v6; v8 <= v7;
    end
  end

  assign out_valid = v8;

endmodule

// ===== rtl/tfuv_sqrt.sv =====
// Pipelined integer square root, one result bit per stage, with a
// sideband word carried alongside. No dependencies.
module tfuv_sqrt #(
  parameter int IN_W   = 66,
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [IN_W-1:0]     radicand,
  input  logic [SIDE_W-1:0]   side_in,
  output logic                out_valid,
  output logic [IN_W/2-1:0]   root,
  output logic [SIDE_W-1:0]   side_out
);

  localparam int R_W = IN_W / 2;
  localparam int RMW = R_W + 3;

  logic [RMW-1:0]    rem_q  [R_W];
  logic [R_W-1:0]    root_q [R_W];
  logic [IN_W-1:0]   rad_q  [R_W];
  logic [SIDE_W-1:0] side_q [R_W];
  logic              v_q    [R_W];

  for (genvar s = 0; s < R_W; s++) begin : g_stage
    logic [RMW-1:0]    rem_p, cur, trial;
    logic [R_W-1:0]    root_p;
    logic [IN_W-1:0]   rad_p;
    logic [SIDE_W-1:0] side_p;
    logic              v_p, take;

    if (s == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = radicand;
      assign side_p = side_in;
      assign v_p    = in_valid;
    end else begin : g_next
      assign rem_p  = rem_q[s-1];
      assign root_p = root_q[s-1];
      assign rad_p  = rad_q[s-1];
      assign side_p = side_q[s-1];
      assign v_p    = v_q[s-1];
    end

    assign cur   = {rem_p[RMW-3:0], rad_p[IN_W-1 -: 2]};
    assign trial = RMW'({root_p, 2'b01});
    assign take  = (cur >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s]  <= take ? (cur - trial) : cur;
        root_q[s] <= {root_p[R_W-2:0], take};
        rad_q[s]  <= {rad_p[IN_W-3:0], 2'b00};
        side_q[s] <= side_p;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[s] <= 1'b0;
      end else if (en) begin
        v_q[s] <= v_p;
      end
    end
  end

  assign out_valid = v_q[R_W-1];
  assign root      = root_q[R_W-1];
  assign side_out  = side_q[R_W-1];

endmodule

// ===== rtl/tfuv_div.sv =====
// Pipelined restoring divider: two numerators over one shared divisor,
// one quotient bit per stage. No dependencies.
module tfuv_div #(
  parameter int N_W    = 66,
  parameter int D_W    = 33,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [N_W-1:0]    num_a,
  input  logic [N_W-1:0]    num_b,
  input  logic [D_W-1:0]    den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [N_W-1:0]    quo_a,
  output logic [N_W-1:0]    quo_b,
  output logic [D_W-1:0]    den_out,
  output logic [SIDE_W-1:0] side_out
);

  // each numerator register shifts out its top bit and takes a quotient bit in
  logic [D_W-1:0]    ra_q   [N_W];
  logic [D_W-1:0]    rb_q   [N_W];
  logic [N_W-1:0]    na_q   [N_W];
  logic [N_W-1:0]    nb_q   [N_W];
  logic [D_W-1:0]    d_q    [N_W];
  logic [SIDE_W-1:0] side_q [N_W];
  logic              v_q    [N_W];

  for (genvar s = 0; s < N_W; s++) begin : g_stage
    logic [D_W-1:0]    ra_p, rb_p, d_p;
    logic [N_W-1:0]    na_p, nb_p;
    logic [SIDE_W-1:0] side_p;
    logic              v_p, ta, tb;
    logic [D_W:0]      ca, cb;

    if (s == 0) begin : g_first
      assign ra_p   = '0;
      assign rb_p   = '0;
      assign na_p   = num_a;
      assign nb_p   = num_b;
      assign d_p    = den;
      assign side_p = side_in;
      assign v_p    = in_valid;
    end else begin : g_next
      assign ra_p   = ra_q[s-1];
      assign rb_p   = rb_q[s-1];
      assign na_p   = na_q[s-1];
      assign nb_p   = nb_q[s-1];
      assign d_p    = d_q[s-1];
      assign side_p = side_q[s-1];
      assign v_p    = v_q[s-1];
    end

    assign ca = {ra_p, na_p[N_W-1]};
    assign cb = {rb_p, nb_p[N_W-1]};
    assign ta = (ca >= {1'b0, d_p});
    assign tb = (cb >= {1'b0, d_p});

    always_ff @(posedge clk) begin
      if (en) begin
        ra_q[s]   <= ta ? D_W'(ca - {1'b0, d_p}) : D_W'(ca);
        rb_q[s]   <= tb ? D_W'(cb - {1'b0, d_p}) : D_W'(cb);
        na_q[s]   <= {na_p[N_W-2:0], ta};
        nb_q[s]   <= {nb_p[N_W-2:0], tb};
        d_q[s]    <= d_p;
        side_q[s] <= side_p;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[s] <= 1'b0;
      end else if (en) begin
        v_q[s] <= v_p;
      end
    end
  end

  assign out_valid = v_q[N_W-1];
  assign quo_a     = na_q[N_W-1];
  assign quo_b     = nb_q[N_W-1];
  assign den_out   = d_q[N_W-1];
  assign side_out  = side_q[N_W-1];

endmodule

// ===== rtl/triangle_flatten_to_uv.sv =====
// Top level of the triangle flattening pipeline.
// Depends on tfuv_pkg, tfuv_front, tfuv_sqrt and tfuv_div.
//
// Usage:
//   Input channel (tri_valid / tri_stall) carries one triangle: three
//   vertices as signed fixed-point coordinates. Output channel
//   (uv_valid / uv_stall) carries the flattened UV triangle and its
//   bounding box as unsigned Q18.16 values, saturated at 2^34-1.
//   The pipeline has eight front stages, one stage per bit of the edge
//   length root, one per bit of the cross-product norm root, one per
//   quotient bit of the shared divider, and the output register.
//   Throughput is one triangle per cycle while the output is not stalled;
//   every stage is fully pipelined.
//   While the output holds an item that the receiver stalls, the whole
//   pipeline freezes and tri_stall is raised; nothing is dropped.
//   Reset clears all valid bits; the pipeline comes out of reset empty and
//   accepts a triangle in the first cycle after reset.
//   A triangle whose first two vertices coincide yields all zero outputs.
module triangle_flatten_to_uv #(
  parameter int COORD_WIDTH = tfuv_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          tri_valid,
  output logic                          tri_stall,
  input  logic signed [COORD_WIDTH-1:0] p1_x,
  input  logic signed [COORD_WIDTH-1:0] p1_y,
  input  logic signed [COORD_WIDTH-1:0] p1_z,
  input  logic signed [COORD_WIDTH-1:0] p2_x,
  input  logic signed [COORD_WIDTH-1:0] p2_y,
  input  logic signed [COORD_WIDTH-1:0] p2_z,
  input  logic signed [COORD_WIDTH-1:0] p3_x,
  input  logic signed [COORD_WIDTH-1:0] p3_y,
  input  logic signed [COORD_WIDTH-1:0] p3_z,
  output logic                          uv_valid,
  input  logic                          uv_stall,
  output logic [tfuv_pkg::OUT_W-1:0]    first_u,
  output logic [tfuv_pkg::OUT_W-1:0]    first_v,
  output logic [tfuv_pkg::OUT_W-1:0]    second_u,
  output logic [tfuv_pkg::OUT_W-1:0]    second_v,
  output logic [tfuv_pkg::OUT_W-1:0]    third_u,
  output logic [tfuv_pkg::OUT_W-1:0]    third_v,
  output logic [tfuv_pkg::OUT_W-1:0]    min_u,
  output logic [tfuv_pkg::OUT_W-1:0]    min_v,
  output logic [tfuv_pkg::OUT_W-1:0]    max_u,
  output logic [tfuv_pkg::OUT_W-1:0]    max_v
);

  localparam int CW    = COORD_WIDTH;
  localparam int OW    = tfuv_pkg::OUT_W;
  localparam int L2W   = 2 * CW + 2;
  localparam int C2W   = 4 * CW + 4;
  localparam int NW    = 2 * CW + 2;
  localparam int LW    = CW + 1;
  localparam int SL_W  = C2W + NW + 1;
  localparam int SC_W  = LW + NW + 1;
  localparam int VW    = (NW + 1 > OW) ? NW + 1 : OW + 1;

  function automatic logic [OW-1:0] sat(input logic [VW-1:0] x);
    sat = (x > VW'(tfuv_pkg::OUT_MAX)) ? tfuv_pkg::OUT_MAX : OW'(x);
  endfunction

  logic en;
  assign en        = !(uv_valid && uv_stall);
  assign tri_stall = !en;

  logic [CW-1:0] pa [3];
  logic [CW-1:0] pb [3];
  logic [CW-1:0] pc [3];

  assign pa[0] = p1_x; assign pa[1] = p1_y; assign pa[2] = p1_z;
  assign pb[0] = p2_x; assign pb[1] = p2_y; assign pb[2] = p2_z;
  assign pc[0] = p3_x; assign pc[1] = p3_y; assign pc[2] = p3_z;

  logic           f_valid, f_dneg;
  logic [L2W-1:0] f_l2;
  logic [C2W-1:0] f_c2;
  logic [NW-1:0]  f_dmag;

  tfuv_front #(.CW(CW)) u_front (
    .clk, .rst, .en,
    .in_valid (tri_valid),
    .p1       (pa),
    .p2       (pb),
    .p3       (pc),
    .out_valid(f_valid),
    .l2       (f_l2),
    .c2       (f_c2),
    .dot_mag  (f_dmag),
    .dot_neg  (f_dneg)
  );

  logic            sl_valid;
  logic [LW-1:0]   sl_root;
  logic [SL_W-1:0] sl_side;

  tfuv_sqrt #(.IN_W(L2W), .SIDE_W(SL_W)) u_sqrt_len (
    .clk, .rst, .en,
    .in_valid (f_valid),
    .radicand (f_l2),
    .side_in  ({f_c2, f_dmag, f_dneg}),
    .out_valid(sl_valid),
    .root     (sl_root),
    .side_out (sl_side)
  );

  logic            sc_valid;
  logic [NW-1:0]   sc_root;
  logic [SC_W-1:0] sc_side;

  tfuv_sqrt #(.IN_W(C2W), .SIDE_W(SC_W)) u_sqrt_cross (
    .clk, .rst, .en,
    .in_valid (sl_valid),
    .radicand (sl_side[SL_W-1 -: C2W]),
    .side_in  ({sl_root, sl_side[NW:0]}),
    .out_valid(sc_valid),
    .root     (sc_root),
    .side_out (sc_side)
  );

  logic          dv_valid, dv_neg;
  logic [NW-1:0] dv_u, dv_q;
  logic [LW-1:0] dv_len;

  tfuv_div #(.N_W(NW), .D_W(LW), .SIDE_W(1)) u_div (
    .clk, .rst, .en,
    .in_valid (sc_valid),
    .num_a    (sc_root),
    .num_b    (sc_side[NW:1]),
    .den      (sc_side[SC_W-1 -: LW]),
    .side_in  (sc_side[0]),
    .out_valid(dv_valid),
    .quo_a    (dv_u),
    .quo_b    (dv_q),
    .den_out  (dv_len),
    .side_out (dv_neg)
  );

  // place the three v values and shift so the smallest is zero
  logic          lz, qneg;
  logic [VW-1:0] u3, q, lv, v1, v2, v3, mv12, mv;

  always_comb begin
    lz   = (dv_len == '0);
    u3   = lz ? '0 : VW'(dv_u);
    q    = lz ? '0 : VW'(dv_q);
    lv   = VW'(dv_len);
    qneg = dv_neg && (q != '0);
    v1   = qneg ? q : '0;
    v2   = qneg ? (lv + q) : lv;
    v3   = qneg ? '0 : q;
    mv12 = (v2 > v1) ? v2 : v1;
    mv   = (v3 > mv12) ? v3 : mv12;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      first_v  <= sat(v1);
      second_v <= sat(v2);
      third_u  <= sat(u3);
      third_v  <= sat(v3);
      max_u    <= sat(u3);
      max_v    <= sat(mv);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      uv_valid <= 1'b0;
    end else if (en) begin
      uv_valid <= dv_valid;
    end
  end

  assign first_u  = '0;
  assign second_u = '0;
  assign min_u    = '0;
  assign min_v    = '0;

`ifndef ASSERT_OFF
  a_max_bounds: assert property (@(posedge clk) disable iff (rst)
    uv_valid |-> (max_v >= first_v && max_v >= second_v && max_v >= third_v))
    else $error("max_v below one of the v values");

  a_min_zero: assert property (@(posedge clk) disable iff (rst)
    uv_valid |-> (first_v == '0 || third_v == '0))
    else $error("no v value shifted to zero");

  a_edge_order: assert property (@(posedge clk) disable iff (rst)
    uv_valid |-> (second_v >= first_v))
    else $error("second vertex v below first vertex v");
`endif

endmodule

// ===== tb/tb_triangle_flatten_to_uv.sv =====
// Testbench for triangle_flatten_to_uv: drives triangles, predicts each UV result.
// Depends on tfuv_pkg and the triangle_flatten_to_uv RTL.
`timescale 1ns / 100ps

module tb_triangle_flatten_to_uv;

  localparam int CW = tfuv_pkg::COORD_WIDTH_DEF;
  localparam int LATENCY = 5 * CW + 14;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [tfuv_pkg::OUT_W-1:0] uv_t;

  typedef struct {
    coord_t p[9];
  } tri_t;

  typedef struct {
    uv_t f[10];
  } flat_t;

  logic clk;
  logic rst;
  logic tri_valid;
  logic tri_stall;
  coord_t p_in[9];
  logic uv_valid;
  logic uv_stall;
  uv_t uv_out[10];

  flat_t flat_q[$];
  int send_idle_pct;
  int recv_stall_pct;
  int errors;
  int sent;
  int received;
  int degenerate_cnt;
  int neg_proj_cnt;
  longint cycles;

  triangle_flatten_to_uv dut (
    .clk(clk), .rst(rst),
    .tri_valid(tri_valid), .tri_stall(tri_stall),
    .p1_x(p_in[0]), .p1_y(p_in[1]), .p1_z(p_in[2]),
    .p2_x(p_in[3]), .p2_y(p_in[4]), .p2_z(p_in[5]),
    .p3_x(p_in[6]), .p3_y(p_in[7]), .p3_z(p_in[8]),
    .uv_valid(uv_valid), .uv_stall(uv_stall),
    .first_u(uv_out[0]), .first_v(uv_out[1]),
    .second_u(uv_out[2]), .second_v(uv_out[3]),
    .third_u(uv_out[4]), .third_v(uv_out[5]),
    .min_u(uv_out[6]), .min_v(uv_out[7]),
    .max_u(uv_out[8]), .max_v(uv_out[9])
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // floor(sqrt(n)) by bitwise trial
  function automatic logic [255:0] isqrt256(logic [255:0] n);
    logic [255:0] r;
    logic [255:0] t;
    r = '0;
    for (int i = 127; i >= 0; i--) begin
      t = r;
      t[i] = 1'b1;
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  function automatic uv_t clamp_out(logic [255:0] v);
    return (v > {222'd0, tfuv_pkg::OUT_MAX}) ? tfuv_pkg::OUT_MAX
                                             : v[tfuv_pkg::OUT_W-1:0];
  endfunction

  function automatic flat_t flatten(tri_t t);
    logic signed [255:0] e[3];
    logic signed [255:0] g[3];
    logic signed [255:0] c[3];
    logic signed [255:0] dot;
    logic [255:0] len2, len, cn2, cn, q, u3, v1, v2, v3, mv;
    logic qneg;
    flat_t r;
    for (int i = 0; i < 3; i++) begin
      e[i] = 256'(t.p[3+i]) - 256'(t.p[i]);
      g[i] = 256'(t.p[6+i]) - 256'(t.p[i]);
    end
    len2 = e[0] * e[0] + e[1] * e[1] + e[2] * e[2];
    len = isqrt256(len2);
    u3 = '0;
    q = '0;
    qneg = 1'b0;
    if (len != 0) begin
      c[0] = e[1] * g[2] - e[2] * g[1];
      c[1] = e[2] * g[0] - e[0] * g[2];
      c[2] = e[0] * g[1] - e[1] * g[0];
      cn2 = c[0] * c[0] + c[1] * c[1] + c[2] * c[2];
      cn = isqrt256(cn2);
      u3 = cn / len;
      dot = e[0] * g[0] + e[1] * g[1] + e[2] * g[2];
      qneg = dot < 0;
      // truncate toward zero on the magnitude
      q = (qneg ? -dot : dot) / len;
      qneg = qneg && (q != 0);
    end
    if (qneg) begin
      v1 = q;
      v2 = len + q;
      v3 = '0;
    end else begin
      v1 = '0;
      v2 = len;
      v3 = q;
    end
    mv = v1;
    if (v2 > mv) mv = v2;
    if (v3 > mv) mv = v3;
    r.f[0] = '0;
    r.f[1] = clamp_out(v1);
    r.f[2] = '0;
    r.f[3] = clamp_out(v2);
    r.f[4] = clamp_out(u3);
    r.f[5] = clamp_out(v3);
    r.f[6] = '0;
    r.f[7] = '0;
    r.f[8] = clamp_out(u3);
    r.f[9] = clamp_out(mv);
    return r;
  endfunction

  // Hold the item until accepted; valid stays high on return, for the next send or idle_inputs to clear.
  task automatic send_tri(tri_t t);
    flat_t exp_flat;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      tri_valid <= 1'b0;
      @(negedge clk);
    end
    for (int i = 0; i < 9; i++) p_in[i] <= t.p[i];
    tri_valid <= 1'b1;
    @(posedge clk);
    while (tri_stall) @(posedge clk);
    exp_flat = flatten(t);
    flat_q.push_back(exp_flat);
    sent++;
    if (exp_flat.f[3] == 0) degenerate_cnt++;
    if (exp_flat.f[1] != 0) neg_proj_cnt++;
    @(negedge clk);
  endtask

  task automatic idle_inputs();
    tri_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
      2: return coord_t'($signed($urandom_range(0, 200)) - 100);
      default: begin
        case ($urandom_range(3))
          0: return coord_t'(32'h7fffffff);
          1: return coord_t'(32'h80000000);
          2: return '0;
          default: return coord_t'(-1);
        endcase
      end
    endcase
  endfunction

  function automatic tri_t rand_tri();
    tri_t t;
    int mode;
    mode = $urandom_range(3);
    for (int i = 0; i < 9; i++) t.p[i] = rand_coord(mode);
    // sometimes make corners one and two coincide
    if ($urandom_range(19) == 0) for (int i = 0; i < 3; i++) t.p[3+i] = t.p[i];
    return t;
  endfunction

  task automatic test_directed();
    tri_t t;
    coord_t hi, lo;
    hi = coord_t'(32'h7fffffff);
    lo = coord_t'(32'h80000000);
    // unit right triangle
    t.p = '{0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh10000, 0};
    send_tri(t);
    // coincident first two corners
    t.p = '{5, 6, 7, 5, 6, 7, 100, -200, 300};
    send_tri(t);
    t.p = '{hi, hi, hi, hi, hi, hi, lo, lo, lo};
    send_tri(t);
    // negative projection
    t.p = '{0, 0, 0, 32'sh10000, 0, 0, -32'sh30000, 32'sh10000, 0};
    send_tri(t);
    // extreme span on every axis
    t.p = '{lo, lo, lo, hi, hi, hi, lo, hi, lo};
    send_tri(t);
    t.p = '{hi, lo, hi, lo, hi, lo, hi, hi, hi};
    send_tri(t);
    t.p = '{lo, 0, 0, hi, 0, 0, lo, 0, 0};
    send_tri(t);
    t.p = '{0, 0, 0, 0, 0, 1, 0, 0, -1};
    send_tri(t);
    t.p = '{-1, -1, -1, 0, 0, 0, 1, 1, 1};
    send_tri(t);
    // collinear, third corner beyond the second
    t.p = '{0, 0, 0, 32'sh20000, 0, 0, 32'sh50000, 0, 0};
    send_tri(t);
    t.p = '{hi, 0, lo, lo, 0, hi, 0, hi, 0};
    send_tri(t);
    idle_inputs();
  endtask

  task automatic test_random(int count, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_tri(rand_tri());
    idle_inputs();
  endtask

  // receiver stall pattern
  always @(negedge clk) begin
    if (rst) uv_stall <= 1'b0;
    else uv_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    flat_t want;
    cycles <= cycles + 1;
    if (!rst && uv_valid && !uv_stall) begin
      received++;
      if (flat_q.size() == 0) begin
        $display("%0t: unexpected result, first_v=%0d", $time, uv_out[1]);
        errors++;
      end else begin
        want = flat_q.pop_front();
        for (int i = 0; i < 10; i++) begin
          if (uv_out[i] !== want.f[i]) begin
            $display("%0t: field %0d expected %0d actual %0d",
                     $time, i, want.f[i], uv_out[i]);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, flat_q.size());
      $display("tb_triangle_flatten_to_uv failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    tri_valid = 1'b0;
    for (int i = 0; i < 9; i++) p_in[i] = '0;
    uv_stall = 1'b0;
    errors = 0;
    sent = 0;
    received = 0;
    degenerate_cnt = 0;
    neg_proj_cnt = 0;
    cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_random(500, 0, 0);
    test_random(500, 77, 0);
    test_random(500, 0, 77);
    test_random(500, 16, 16);
    recv_stall_pct = 0;
    while (flat_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    $display("sent %0d triangles, checked %0d results", sent, received);
    $display("coincident-edge cases %0d, negative projections %0d",
             degenerate_cnt, neg_proj_cnt);
    if (errors == 0) begin
      $display("tb_triangle_flatten_to_uv passed");
    end else begin
      $display("tb_triangle_flatten_to_uv failed");
    end
    $finish;
  end

endmodule
